>>> design/four_sum_index_search_defines.svh
// ----------------------------------------------------------------------------
// four_sum_index_search_defines
// assertion macros shared by the four-sum search design
// ----------------------------------------------------------------------------
`ifndef FOUR_SUM_INDEX_SEARCH_DEFINES_SVH
`define FOUR_SUM_INDEX_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define FSIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FSIS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FSIS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FSIS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/fsis_pkg.sv
// ----------------------------------------------------------------------------
// fsis_pkg
// shared types and constants of the four-sum search
// ----------------------------------------------------------------------------
package fsis_pkg;
    localparam int MAX_ITEMS = 1024;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;
    localparam int POS_W     = 11;
    localparam int SUM_W     = VAL_W + 2;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
    } entry_t;

    typedef struct packed {
        logic   insert;
        logic   shift;
        entry_t word;
    } chain_ctrl_t;
endpackage

>>> design/four_sum_index_search.sv
// load: one word per cycle, sorted on entry by the cell chain (stall low)
// after last: n cycles to drain the chain into the sorted store, then
// 2 cycles per outer index, 2 per inner index, 3 per pointer step, 1 for result
// result held until taken; then the next set may load
// reset (rst_n low, async): set empty, drop flag clear, target_sum 0
// ----------------------------------------------------------------------------
// four_sum_index_search
// sorts a loaded set and searches for four entries adding to target_sum
// ----------------------------------------------------------------------------
`include "four_sum_index_search_defines.svh"
module four_sum_index_search
    import fsis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [VAL_W-1:0]        cfg_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    found,
    output logic [POS_W-1:0]        first_position,
    output logic [POS_W-1:0]        second_position,
    output logic [POS_W-1:0]        third_position,
    output logic [POS_W-1:0]        fourth_position,
    output logic                    overflowed
);
    chain_ctrl_t ctrl;
    entry_t      head;

    fsis_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .head  (head)
    );

    fsis_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .value           (value),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .head            (head),
        .ctrl            (ctrl),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .first_position  (first_position),
        .second_position (second_position),
        .third_position  (third_position),
        .fourth_position (fourth_position),
        .overflowed      (overflowed)
    );

    // no word is loaded while a result is pending
    `FSIS_ASSERT_IMP(a_no_load_with_result, clk, rst_n, in_valid && !in_stall, !out_valid)
    // a stalled result stays
    `FSIS_ASSERT_NXT(a_result_holds, clk, rst_n, out_valid && out_stall, out_valid)
    // not found carries zero positions
    `FSIS_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !found, first_position == '0)
    // drain only shifts, never inserts
    `FSIS_ASSERT_IMP(a_shift_excl, clk, rst_n, ctrl.shift, !ctrl.insert)
endmodule

>>> design/fsis_cell.sv
// ----------------------------------------------------------------------------
// fsis_cell
// one slot of the insertion sort chain
// ----------------------------------------------------------------------------
module fsis_cell
    import fsis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  entry_t      prev_entry,
    input  logic        prev_ahead,
    input  entry_t      next_entry,
    output entry_t      entry,
    output logic        ahead
);
    entry_t slot_reg;
    entry_t slot_next;

    // new word sorts ahead of this slot; equal values keep arrival order
    assign ahead = !slot_reg.valid || (ctrl.word.value < slot_reg.value);
    assign entry = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.shift)
        begin
            slot_next = next_entry;
        end
        else if (ctrl.insert && ahead)
        begin
            slot_next = prev_ahead ? prev_entry : ctrl.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end
endmodule

>>> design/fsis_chain.sv
// ----------------------------------------------------------------------------
// fsis_chain
// row of sort cells, drained from the head
// ----------------------------------------------------------------------------
module fsis_chain
    import fsis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    output entry_t      head
);
    entry_t entries [MAX_ITEMS];
    logic   aheads  [MAX_ITEMS];
    entry_t empty_entry;

    assign empty_entry = '0;
    assign head        = entries[0];

    for (genvar c = 0; c < MAX_ITEMS; c++)
    begin : g_cell
        entry_t prev_e;
        logic   prev_b;
        entry_t next_e;
        if (c == 0)
        begin : g_first
            assign prev_e = empty_entry;
            assign prev_b = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = entries[c-1];
            assign prev_b = aheads[c-1];
        end
        if (c == MAX_ITEMS - 1)
        begin : g_last
            assign next_e = empty_entry;
        end
        else
        begin : g_inner
            assign next_e = entries[c+1];
        end
        fsis_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .prev_ahead (prev_b),
            .next_entry (next_e),
            .entry      (entries[c]),
            .ahead      (aheads[c])
        );
    end
endmodule

>>> design/fsis_engine.sv
// ----------------------------------------------------------------------------
// fsis_engine
// load control, sorted store and two-pointer search sequencer
// ----------------------------------------------------------------------------
module fsis_engine
    import fsis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [VAL_W-1:0]        cfg_data,
    input  entry_t                  head,
    output chain_ctrl_t             ctrl,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    found,
    output logic [POS_W-1:0]        first_position,
    output logic [POS_W-1:0]        second_position,
    output logic [POS_W-1:0]        third_position,
    output logic [POS_W-1:0]        fourth_position,
    output logic                    overflowed
);
    typedef enum logic [10:0] {
        S_LOAD   = 11'b00000000001,
        S_DRAIN  = 11'b00000000010,
        S_RI     = 11'b00000000100,
        S_WI     = 11'b00000001000,
        S_RJ     = 11'b00000010000,
        S_WJ     = 11'b00000100000,
        S_RKL    = 11'b00001000000,
        S_WKL    = 11'b00010000000,
        S_CMP    = 11'b00100000000,
        S_RESULT = 11'b01000000000,
        S_HOLD   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
    } mem_word_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    drop_reg, drop_next;
    logic signed [VAL_W-1:0] target_reg;
    logic [IDX_W-1:0]        a_reg, a_next;
    logic [IDX_W-1:0]        i_reg, i_next, j_reg, j_next, k_reg, k_next, l_reg, l_next;
    logic signed [VAL_W-1:0] vi_reg, vi_next;
    logic signed [SUM_W-1:0] vij_reg, vij_next, sum_reg, sum_next;
    logic [POS_W-1:0]        pi_reg, pi_next, pj_reg, pj_next, pk_reg, pk_next;
    logic [POS_W-1:0]        pl_reg, pl_next;
    logic                    hit_reg, hit_next;
    logic                    ov_reg, ov_next;
    logic [POS_W-1:0]        o1_reg, o2_reg, o3_reg, o4_reg;
    logic                    of_reg, oo_reg;

    mem_word_t               mem [MAX_ITEMS];
    mem_word_t               rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0]        addr_a;
    logic [CNT_W-1:0]        n_m1, n_m3, n_m4;
    logic [CNT_W-1:0]        i_inc, j_inc;
    logic [IDX_W-1:0]        k_step, l_step;
    logic                    accept, full;
    logic signed [SUM_W-1:0] target_ext;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_LOAD);
    assign cfg_ready  = 1'b1;
    assign full       = (cnt_reg == CNT_W'(MAX_ITEMS));
    assign n_m1       = cnt_reg - CNT_W'(1);
    assign n_m3       = cnt_reg - CNT_W'(3);
    assign n_m4       = cnt_reg - CNT_W'(4);
    assign i_inc      = CNT_W'(i_reg) + CNT_W'(1);
    assign j_inc      = CNT_W'(j_reg) + CNT_W'(1);
    assign target_ext = SUM_W'(target_reg);

    assign ctrl.insert      = accept && !full;
    assign ctrl.shift       = (state_reg == S_DRAIN);
    assign ctrl.word.valid  = 1'b1;
    assign ctrl.word.value  = value;
    assign ctrl.word.pos    = POS_W'(cnt_reg + CNT_W'(1));

    assign out_valid       = oo_reg;
    assign found           = of_reg;
    assign first_position  = o1_reg;
    assign second_position = o2_reg;
    assign third_position  = o3_reg;
    assign fourth_position = o4_reg;
    assign overflowed      = ov_reg;

    always_comb
    begin
        case (state_reg)
            S_RI:    addr_a = i_reg;
            S_RJ:    addr_a = j_reg;
            default: addr_a = k_reg;
        endcase
    end

    // the pointer move of one walk step
    always_comb
    begin
        if (sum_reg < target_ext)
        begin
            k_step = k_reg + IDX_W'(1);
            l_step = l_reg;
        end
        else
        begin
            k_step = k_reg;
            l_step = l_reg - IDX_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        a_next     = a_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        vi_next    = vi_reg;
        vij_next   = vij_reg;
        sum_next   = sum_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        pk_next    = pk_reg;
        pl_next    = pl_reg;
        hit_next   = hit_reg;
        ov_next    = ov_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (last)
                    begin
                        a_next     = '0;
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                a_next = a_reg + IDX_W'(1);
                if (CNT_W'(a_reg) == n_m1)
                begin
                    hit_next = 1'b0;
                    i_next   = '0;
                    if (cnt_reg < CNT_W'(4))
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_RI;
                    end
                end
            end
            S_RI:
            begin
                state_next = S_WI;
            end
            S_WI:
            begin
                vi_next    = rd_a_reg.value;
                pi_next    = rd_a_reg.pos;
                j_next     = i_reg + IDX_W'(1);
                state_next = S_RJ;
            end
            S_RJ:
            begin
                state_next = S_WJ;
            end
            S_WJ:
            begin
                vij_next   = SUM_W'(vi_reg) + SUM_W'(rd_a_reg.value);
                pj_next    = rd_a_reg.pos;
                k_next     = j_reg + IDX_W'(1);
                l_next     = n_m1[IDX_W-1:0];
                state_next = S_RKL;
            end
            S_RKL:
            begin
                state_next = S_WKL;
            end
            S_WKL:
            begin
                sum_next   = vij_reg + SUM_W'(rd_a_reg.value) + SUM_W'(rd_b_reg.value);
                pk_next    = rd_a_reg.pos;
                pl_next    = rd_b_reg.pos;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sum_reg == target_ext)
                begin
                    hit_next   = 1'b1;
                    state_next = S_RESULT;
                end
                else if (k_step < l_step)
                begin
                    k_next     = k_step;
                    l_next     = l_step;
                    state_next = S_RKL;
                end
                else if (j_inc <= n_m3)
                begin
                    j_next     = j_inc[IDX_W-1:0];
                    state_next = S_RJ;
                end
                else if (i_inc <= n_m4)
                begin
                    i_next     = i_inc[IDX_W-1:0];
                    state_next = S_RI;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                ov_next    = drop_reg;
                cnt_next   = '0;
                drop_next  = 1'b0;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_stall)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
            target_reg <= '0;
            oo_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= cfg_data;
            end
            if (state_reg == S_RESULT)
            begin
                oo_reg <= 1'b1;
            end
            else if (oo_reg && !out_stall)
            begin
                oo_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        l_reg   <= l_next;
        vi_reg  <= vi_next;
        vij_reg <= vij_next;
        sum_reg <= sum_next;
        pi_reg  <= pi_next;
        pj_reg  <= pj_next;
        pk_reg  <= pk_next;
        pl_reg  <= pl_next;
        hit_reg <= hit_next;
        ov_reg  <= ov_next;
        if (state_reg == S_RESULT)
        begin
            of_reg <= hit_reg;
            o1_reg <= hit_reg ? pi_reg : '0;
            o2_reg <= hit_reg ? pj_reg : '0;
            o3_reg <= hit_reg ? pk_reg : '0;
            o4_reg <= hit_reg ? pl_reg : '0;
        end
    end

    // sorted store, written during drain, two registered read ports
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DRAIN)
        begin
            mem[a_reg] <= '{value: head.value, pos: head.pos};
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[l_reg];
    end
endmodule
